// ===== rtl/fair_upload_admission_queue_core_assert.svh =====
// Assertion macros for the fair upload admission queue.
// Included by the checker module; depends on nothing else.
`ifndef FAIR_UPLOAD_ADMISSION_QUEUE_CORE_ASSERT_SVH
`define FAIR_UPLOAD_ADMISSION_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FUAQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fuaq: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define FUAQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fuaq: next-cycle check failed");

`endif

// ===== rtl/fuaq_pkg.sv =====
// Shared types and constants of the fair upload admission queue.
// No dependencies; used by the core and its checker.
`timescale 1ns / 1ps

package fuaq_pkg;

  // Field widths fixed by the stream format.
  localparam int UserIdW   = 16;
  localparam int ActCountW = 8;
  localparam int PosW      = 5;
  localparam int ExpW      = 5;
  localparam int CtrW      = 16;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 16;
  localparam int SDataW    = 40;
  localparam int MDataW    = 16;

  // Idle counters saturate here.
  localparam logic [CtrW-1:0] CtrMax = '1;

  // Open slots reported when there is no slot limit.
  localparam logic [ActCountW-1:0] UnlimitedSlots = 8'd9;

  // Register reset values (timeout is two minutes of one-second ticks).
  localparam logic                 RstUploadsDisabled = 1'b0;
  localparam logic                 RstSlotsUnlimited  = 1'b1;
  localparam logic [ActCountW-1:0] RstSlotLimit       = 8'd0;
  localparam logic [ActCountW-1:0] RstMaxPerUser      = 8'd1;
  localparam logic [CtrW-1:0]      RstIdleTimeout     = 16'd120;

  typedef enum logic [2:0] {
    VERDICT_ALLOW        = 3'd0,
    VERDICT_NOT_SHARED   = 3'd1,
    VERDICT_STALE        = 3'd2,
    VERDICT_PER_USER_MAX = 3'd3,
    VERDICT_QUEUED       = 3'd4
  } verdict_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_UPLOADS_DISABLED = 3'd0,
    CFG_SLOTS_UNLIMITED  = 3'd1,
    CFG_SLOT_LIMIT       = 3'd2,
    CFG_MAX_PER_USER     = 3'd3,
    CFG_IDLE_TIMEOUT     = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_COMPACT,
    ST_DONE
  } state_e;

  typedef struct packed {
    verdict_e          verdict;
    logic [PosW-1:0]   position;
    logic              full;
    logic [ExpW-1:0]   expired;
  } result_t;

endpackage

// ===== rtl/fair_upload_admission_queue_core.sv =====
// Fair upload admission queue: request checks, slot decision and a waiting
// queue held in one entry RAM (user id and idle counter per entry). Depends on
// fuaq_pkg and fuaq_ram.
//
// Each beat on the input stream is either an upload request or a time tick,
// and produces exactly one result beat. One beat is processed at a time; the
// output register lets the next beat be accepted while a result waits. A
// request rejected by the share, stale or per-user checks, allowed with more
// than one open slot, or allowed with one open slot and an empty queue, goes
// straight to its result. Otherwise the queue RAM is swept one entry per cycle
// through its single read port, each entry being examined the cycle after it
// is read: a queued request stops the sweep when its user is found or all n
// waiting users are read, and an allowed request that removes the head entry,
// found as the first entry read, starts a second sweep in which the remaining
// entries are copied down one place. A tick ages every entry in one sweep and
// closes up the queue over expired entries in the same pass. A result beat
// that is not taken holds back the next result, and with it the input.
// The queue RAM needs no clearing after reset: only entries below the fill
// count are ever read.
`timescale 1ns / 1ps

module fair_upload_admission_queue_core #(
  parameter int QUEUE_DEPTH  = 16,
  parameter int USER_ID_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input beats.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // user_id[15:0], is_shared[16], is_stale[17], user_active_count[25:18],
  // total_active_count[33:26], zero fill above.
  input  logic [fuaq_pkg::SDataW-1:0]   s_axis_tdata,
  // action: 0 upload request, 1 time tick.
  input  logic                          s_axis_tuser,
  // Result beats.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // verdict[2:0], queue_position[7:3], queue_full[8], expired_count[13:9],
  // zero fill above.
  output logic [fuaq_pkg::MDataW-1:0]   m_axis_tdata,
  // Configuration writes.
  input  logic                          cfg_we_i,
  input  logic [fuaq_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [fuaq_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int CntW  = $clog2(QUEUE_DEPTH + 1);
  localparam int IdxW  = $clog2(QUEUE_DEPTH);
  localparam int EntW  = fuaq_pkg::CtrW + USER_ID_BITS;
  localparam int CtrW  = fuaq_pkg::CtrW;
  localparam int ActW  = fuaq_pkg::ActCountW;

  // Configuration registers.
  logic            cfg_disabled_q;
  logic            cfg_unlimited_q;
  logic [ActW-1:0] cfg_slot_limit_q;
  logic [ActW-1:0] cfg_max_per_user_q;
  logic [CtrW-1:0] cfg_timeout_q;

  // Control and working registers.
  fuaq_pkg::state_e  state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CntW-1:0]   rd_idx_q, rd_idx_d;
  logic [CntW-1:0]   wr_idx_q, wr_idx_d;
  logic [CntW-1:0]   exp_q, exp_d;
  logic              pend_q, pend_d;
  logic [IdxW-1:0]   pend_idx_q, pend_idx_d;
  logic              age_mode_q, age_mode_d;
  logic              slot_one_q, slot_one_d;
  logic              out_valid_q, out_valid_d;
  logic [USER_ID_BITS-1:0]        req_user_q, req_user_d;
  fuaq_pkg::result_t              res_q, res_d;
  logic [fuaq_pkg::MDataW-1:0]    out_data_q, out_data_d;

  // Input fields.
  logic                           in_action;
  logic [fuaq_pkg::UserIdW-1:0]   in_user_id;
  logic                           in_shared;
  logic                           in_stale;
  logic [ActW-1:0]                in_user_active;
  logic [ActW-1:0]                in_total_active;
  logic [USER_ID_BITS-1:0]        in_user;
  logic                           in_accept;

  assign in_action       = s_axis_tuser;
  assign in_user_id      = s_axis_tdata[15:0];
  assign in_shared       = s_axis_tdata[16];
  assign in_stale        = s_axis_tdata[17];
  assign in_user_active  = s_axis_tdata[25:18];
  assign in_total_active = s_axis_tdata[33:26];
  assign in_user         = USER_ID_BITS'(in_user_id);

  assign s_axis_tready = (state_q == fuaq_pkg::ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // Open slots and the request checks.
  logic [ActW-1:0] avail_slots;
  logic            slots_many;
  logic            slots_one;
  logic            over_user_max;

  always_comb begin
    priority if (cfg_disabled_q) begin
      avail_slots = '0;
    end else if (cfg_unlimited_q) begin
      avail_slots = fuaq_pkg::UnlimitedSlots;
    end else if (cfg_slot_limit_q > in_total_active) begin
      avail_slots = cfg_slot_limit_q - in_total_active;
    end else begin
      avail_slots = '0;
    end
  end

  assign slots_many    = (avail_slots > ActW'(1));
  assign slots_one     = (avail_slots == ActW'(1));
  assign over_user_max = (cfg_max_per_user_q != '0) && (in_user_active >= cfg_max_per_user_q);

  // Queue RAM and its access signals.
  logic             ram_we;
  logic [IdxW-1:0]  ram_waddr;
  logic [EntW-1:0]  ram_wdata;
  logic             ram_re;
  logic [EntW-1:0]  ram_rdata;
  logic [USER_ID_BITS-1:0] rd_user;
  logic [CtrW-1:0]  rd_ctr;

  assign rd_user = ram_rdata[USER_ID_BITS-1:0];
  assign rd_ctr  = ram_rdata[EntW-1:USER_ID_BITS];

  fuaq_ram #(
    .Width (EntW),
    .Depth (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q[IdxW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Sweep status: each read is processed in the cycle after it is issued.
  logic            more_to_read;
  logic            search_hit;
  logic            search_miss;
  logic            sweep_end;
  logic [CtrW-1:0] aged_ctr;
  logic            drop_entry;
  logic            out_free;

  assign more_to_read = (rd_idx_q != cnt_q);
  assign search_hit   = pend_q && (rd_user == req_user_q);
  assign search_miss  = !search_hit && !more_to_read;
  assign sweep_end    = !pend_q && !more_to_read;
  assign aged_ctr     = (rd_ctr == fuaq_pkg::CtrMax) ? rd_ctr : rd_ctr + CtrW'(1);
  assign drop_entry   = age_mode_q ? (aged_ctr >= cfg_timeout_q) : (pend_idx_q == '0);
  assign out_free     = !out_valid_q || m_axis_tready;

  // Read issue: one entry per cycle while sweeping.
  always_comb begin
    unique case (state_q)
      fuaq_pkg::ST_SEARCH:  ram_re = more_to_read && !search_hit;
      fuaq_pkg::ST_COMPACT: ram_re = more_to_read;
      default:              ram_re = 1'b0;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fuaq_pkg::ST_IDLE: begin
        if (in_accept) begin
          priority if (in_action) begin
            state_d = fuaq_pkg::ST_COMPACT;
          end else if (!in_shared || in_stale || over_user_max || slots_many) begin
            state_d = fuaq_pkg::ST_DONE;
          end else if (slots_one && (cnt_q == '0)) begin
            state_d = fuaq_pkg::ST_DONE;
          end else begin
            state_d = fuaq_pkg::ST_SEARCH;
          end
        end
      end
      fuaq_pkg::ST_SEARCH: begin
        priority if (search_hit && slot_one_q && (pend_idx_q == '0)) begin
          state_d = fuaq_pkg::ST_COMPACT;
        end else if (search_hit || search_miss) begin
          state_d = fuaq_pkg::ST_DONE;
        end else begin
          state_d = fuaq_pkg::ST_SEARCH;
        end
      end
      fuaq_pkg::ST_COMPACT: begin
        if (sweep_end) begin
          state_d = fuaq_pkg::ST_DONE;
        end
      end
      fuaq_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = fuaq_pkg::ST_IDLE;
        end
      end
      default: state_d = fuaq_pkg::ST_IDLE;
    endcase
  end

  // Datapath, RAM writes and result.
  always_comb begin
    cnt_d       = cnt_q;
    rd_idx_d    = rd_idx_q;
    wr_idx_d    = wr_idx_q;
    exp_d       = exp_q;
    pend_d      = 1'b0;
    pend_idx_d  = rd_idx_q[IdxW-1:0];
    age_mode_d  = age_mode_q;
    slot_one_d  = slot_one_q;
    req_user_d  = req_user_q;
    res_d       = res_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    ram_we      = 1'b0;
    ram_waddr   = wr_idx_q[IdxW-1:0];
    ram_wdata   = {CtrW'(0), req_user_q};

    unique case (state_q)
      fuaq_pkg::ST_IDLE: begin
        if (in_accept) begin
          rd_idx_d   = '0;
          wr_idx_d   = '0;
          exp_d      = '0;
          age_mode_d = in_action;
          slot_one_d = slots_one;
          req_user_d = in_user;
          res_d      = '{verdict: fuaq_pkg::VERDICT_ALLOW, position: '0, full: 1'b0,
                         expired: '0};
          priority if (in_action) begin
            res_d.verdict = fuaq_pkg::VERDICT_ALLOW;
          end else if (!in_shared) begin
            res_d.verdict = fuaq_pkg::VERDICT_NOT_SHARED;
          end else if (in_stale) begin
            res_d.verdict = fuaq_pkg::VERDICT_STALE;
          end else if (over_user_max) begin
            res_d.verdict = fuaq_pkg::VERDICT_PER_USER_MAX;
          end else begin
            res_d.verdict = fuaq_pkg::VERDICT_ALLOW;
          end
        end
      end

      fuaq_pkg::ST_SEARCH: begin
        if (ram_re) begin
          rd_idx_d = rd_idx_q + CntW'(1);
        end
        pend_d = ram_re;
        priority if (search_hit && slot_one_q && (pend_idx_q == '0)) begin
          // Head user takes the last slot: close up the queue over the head.
          res_d.verdict = fuaq_pkg::VERDICT_ALLOW;
          rd_idx_d      = '0;
          wr_idx_d      = '0;
          pend_d        = 1'b0;
        end else if (search_hit) begin
          // Known user: restart its idle counter in place.
          res_d.verdict  = fuaq_pkg::VERDICT_QUEUED;
          res_d.position = fuaq_pkg::PosW'(pend_idx_q);
          ram_we         = 1'b1;
          ram_waddr      = pend_idx_q;
        end else if (search_miss) begin
          res_d.verdict = fuaq_pkg::VERDICT_QUEUED;
          if (cnt_q != CntW'(QUEUE_DEPTH)) begin
            // New user goes to the tail.
            res_d.position = fuaq_pkg::PosW'(cnt_q);
            ram_we         = 1'b1;
            ram_waddr      = cnt_q[IdxW-1:0];
            cnt_d          = cnt_q + CntW'(1);
          end else begin
            res_d.full = 1'b1;
          end
        end else begin
          // Still sweeping: nothing is decided yet.
        end
      end

      fuaq_pkg::ST_COMPACT: begin
        if (ram_re) begin
          rd_idx_d = rd_idx_q + CntW'(1);
        end
        pend_d = ram_re;
        // Keep or drop the entry read last cycle; writes trail the reads.
        if (pend_q) begin
          if (drop_entry) begin
            if (age_mode_q) begin
              exp_d = exp_q + CntW'(1);
            end
          end else begin
            ram_we    = 1'b1;
            ram_waddr = wr_idx_q[IdxW-1:0];
            ram_wdata = {(age_mode_q ? aged_ctr : rd_ctr), rd_user};
            wr_idx_d  = wr_idx_q + CntW'(1);
          end
        end
        if (sweep_end) begin
          cnt_d         = wr_idx_q;
          res_d.expired = fuaq_pkg::ExpW'(exp_q);
        end
      end

      fuaq_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = fuaq_pkg::MDataW'({res_q.expired, res_q.full, res_q.position,
                                           res_q.verdict});
        end
      end

      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fuaq_pkg::ST_IDLE;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk_i) begin
    rd_idx_q   <= rd_idx_d;
    wr_idx_q   <= wr_idx_d;
    exp_q      <= exp_d;
    pend_idx_q <= pend_idx_d;
    age_mode_q <= age_mode_d;
    slot_one_q <= slot_one_d;
    req_user_q <= req_user_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_disabled_q     <= fuaq_pkg::RstUploadsDisabled;
      cfg_unlimited_q    <= fuaq_pkg::RstSlotsUnlimited;
      cfg_slot_limit_q   <= fuaq_pkg::RstSlotLimit;
      cfg_max_per_user_q <= fuaq_pkg::RstMaxPerUser;
      cfg_timeout_q      <= fuaq_pkg::RstIdleTimeout;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fuaq_pkg::CFG_UPLOADS_DISABLED: cfg_disabled_q     <= cfg_data_i[0];
        fuaq_pkg::CFG_SLOTS_UNLIMITED:  cfg_unlimited_q    <= cfg_data_i[0];
        fuaq_pkg::CFG_SLOT_LIMIT:       cfg_slot_limit_q   <= cfg_data_i[ActW-1:0];
        fuaq_pkg::CFG_MAX_PER_USER:     cfg_max_per_user_q <= cfg_data_i[ActW-1:0];
        fuaq_pkg::CFG_IDLE_TIMEOUT:     cfg_timeout_q      <= cfg_data_i[CtrW-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/fuaq_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module fuaq_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/fuaq_checker.sv =====
// Port-level checks of the fair upload admission queue, bound to the core.
// Depends on fuaq_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "fair_upload_admission_queue_core_assert.svh"

module fuaq_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [fuaq_pkg::MDataW-1:0] m_axis_tdata
);

  // A stalled result beat stays put.
  `FUAQ_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // Only a queued verdict carries a position or the full flag.
  `FUAQ_ASSERT_NOW(a_pos_only_queued, clk_i, rst_ni, m_axis_tvalid && (m_axis_tdata[2:0] != fuaq_pkg::VERDICT_QUEUED), (m_axis_tdata[7:3] == 5'd0) && !m_axis_tdata[8])

  // A user refused for a full queue has no position.
  `FUAQ_ASSERT_NOW(a_full_no_pos, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[8], m_axis_tdata[7:3] == 5'd0)

  // One beat is worked on at a time.
  `FUAQ_ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

bind fair_upload_admission_queue_core fuaq_checker u_fuaq_checker (.*);
